// ===== hdl/scss_pkg.sv =====
`default_nettype none

package scss_pkg;

  // input item kinds
  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // play status codes
  localparam logic [1:0] STAT_PLAYING = 2'd0;
  localparam logic [1:0] STAT_EOD     = 2'd1;
  localparam logic [1:0] STAT_UNSUP   = 2'd2;

  // command bytes
  localparam logic [7:0] OP_WRITE  = 8'hB3;
  localparam logic [7:0] OP_DELAY  = 8'h61;
  localparam logic [7:0] OP_WAIT_A = 8'h62;
  localparam logic [7:0] OP_WAIT_B = 8'h63;
  localparam logic [7:0] OP_END    = 8'h66;
  localparam logic [3:0] OP_SKIP_HI = 4'h7;   // 0x70..0x7F are one-byte no-ops

  localparam logic [7:0] WR_ADDR_LIMIT = 8'h30;
  localparam logic [6:0] SKIP_MAX      = 7'd127;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_in;
  } scss_in_t;

  typedef struct packed {
    logic       is_write;
    logic [5:0] reg_offset;
    logic [7:0] reg_value;
    logic [1:0] play_status;
    logic [6:0] frames_left;
    logic [7:0] bad_opcode;
    logic       last;
  } scss_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OP,
    ST_OP,
    ST_ARG1,
    ST_ARG2,
    ST_EMIT,
    ST_DIV,
    ST_REPORT
  } scss_state_e;

endpackage

`default_nettype wire

// ===== hdl/scss_frame_div.sv =====
`default_nettype none

// Frame skip from a 16-bit delay: delay / SAMPLES_PER_FRAME by reciprocal
// multiplication, registered, result saturated to the 7-bit skip count.
// With Shift = 16 + ceil(log2(d)) and Recip = ceil(2^Shift / d), the product
// shifted right by Shift is the exact quotient for every 16-bit dividend.
// done_o rises the cycle after start_i.
module scss_frame_div import scss_pkg::*; #(
  parameter int unsigned SAMPLES_PER_FRAME = 735
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  output logic             done_o,
  output logic [6:0]       quotient_o
);

  localparam int unsigned Shift     = 16 + $clog2(SAMPLES_PER_FRAME);
  localparam logic [63:0] RecipWide = ((64'd1 << Shift) + 64'(SAMPLES_PER_FRAME) - 64'd1)
                                      / 64'(SAMPLES_PER_FRAME);
  localparam logic [17:0] Recip     = RecipWide[17:0];

  logic        done_q;
  logic [6:0]  quo_q, quo_d;
  logic [33:0] prod;
  logic [15:0] quo_full;

  always_comb begin
    prod     = 34'(dividend_i) * 34'(Recip);
    quo_full = 16'(prod >> Shift);
    quo_d    = (quo_full > 16'(SKIP_MAX)) ? SKIP_MAX : quo_full[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hdl/sound_command_stream_sequencer_unit.sv =====
`default_nettype none

// Channel  | Direction | Signals                         | Payload
// in       | input     | in_valid_i / in_ready_o         | scss_in_t  (kind, byte_in)
// out      | output    | out_valid_o / out_ready_i       | scss_out_t (one result)
// cfg      | input     | cfg_valid_i / cfg_ready_o       | stream_length, 32 bits
//
// A push or a restart is taken in ST_IDLE; a tick that only reports adds ST_REPORT.
// A parsing tick walks the ring through one read port: ST_RD_OP and ST_OP per
// command, ST_ARG1 and ST_ARG2 for a three-byte command plus ST_EMIT per write
// result, ST_REPORT for the final report, ST_DIV for a delay's reciprocal multiply.
// in_ready_o is low from a tick transfer until its final result is loaded.
// Results wait in an output register; out_ready_i low holds the walk in a result state.
// Reset clears control state only; the ring contents are never read unwritten.
module sound_command_stream_sequencer_unit import scss_pkg::*; #(
  parameter int unsigned FIFO_DEPTH        = 128,
  parameter int unsigned SAMPLES_PER_FRAME = 735
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire scss_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output scss_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(k);
    if (s >= (PW+1)'(FIFO_DEPTH)) s = s - (PW+1)'(FIFO_DEPTH);
    return s[PW-1:0];
  endfunction

  scss_state_e state_q, state_d;

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [31:0]   consumed_q, consumed_d;
  logic [31:0]   len_q;
  logic [6:0]    skip_q, skip_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    bad_q, bad_d;
  logic [7:0]    op_q, op_d;
  logic [7:0]    arg_q, arg_d;
  logic [7:0]    val_q, val_d;

  logic [7:0]    ring [FIFO_DEPTH];
  logic [PW-1:0] raddr;
  logic [7:0]    rdata_q;

  logic          out_valid_q, out_valid_d;
  scss_out_t     out_data_q, out_data_d;

  logic          in_fire, slot_free, tick_parse;
  logic [1:0]    consume_n;
  logic          div_start, div_done;
  logic [6:0]    div_quo;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign tick_parse  = (status_q == STAT_PLAYING) && (skip_q == '0) && (consumed_q < len_q);
  assign div_start   = (state_q == ST_ARG2) && (op_q != OP_WRITE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.kind == KIND_TICK) begin
          state_d = tick_parse ? ST_RD_OP : ST_REPORT;
        end
      end
      ST_RD_OP: begin
        state_d = (fill_q == '0) ? ST_REPORT : ST_OP;
      end
      ST_OP: begin
        case (rdata_q) inside
          OP_WRITE, OP_DELAY: state_d = (fill_q < CW'(3)) ? ST_REPORT : ST_ARG1;
          OP_WAIT_A, OP_WAIT_B, OP_END: state_d = ST_REPORT;
          default: state_d = (rdata_q[7:4] == OP_SKIP_HI) ? ST_RD_OP : ST_REPORT;
        endcase
      end
      ST_ARG1: state_d = ST_ARG2;
      ST_ARG2: begin
        if (op_q == OP_WRITE) begin
          state_d = (arg_q < WR_ADDR_LIMIT) ? ST_EMIT : ST_RD_OP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_EMIT:   state_d = slot_free ? ST_RD_OP : ST_EMIT;
      ST_DIV:    state_d = div_done ? ST_REPORT : ST_DIV;
      ST_REPORT: state_d = slot_free ? ST_IDLE : ST_REPORT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    fill_d      = fill_q;
    consumed_d  = consumed_q;
    skip_d      = skip_q;
    status_d    = status_q;
    bad_d       = bad_q;
    op_d        = op_q;
    arg_d       = arg_q;
    val_d       = val_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    consume_n   = 2'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.kind)
            KIND_PUSH: begin
              if (fill_q < CW'(FIFO_DEPTH)) begin
                wr_ptr_d = ptr_add(wr_ptr_q, 2'd1);
                fill_d   = fill_q + CW'(1);
              end
            end
            KIND_TICK: begin
              if (status_q == STAT_PLAYING) begin
                if (skip_q != '0) begin
                  skip_d = skip_q - 7'd1;
                end else if (consumed_q >= len_q) begin
                  status_d = STAT_EOD;
                end
              end
            end
            KIND_RESTART: begin
              wr_ptr_d   = '0;
              fill_d     = '0;
              consumed_d = '0;
              skip_d     = '0;
              status_d   = STAT_PLAYING;
              bad_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD_OP: ;
      ST_OP: begin
        op_d = rdata_q;
        case (rdata_q) inside
          OP_WRITE, OP_DELAY: ;
          OP_WAIT_A, OP_WAIT_B: consume_n = 2'd1;
          OP_END: status_d = STAT_EOD;
          default: begin
            if (rdata_q[7:4] == OP_SKIP_HI) begin
              consume_n = 2'd1;
            end else begin
              bad_d    = rdata_q;
              status_d = STAT_UNSUP;
            end
          end
        endcase
      end
      ST_ARG1: arg_d = rdata_q;
      ST_ARG2: begin
        val_d     = rdata_q;
        consume_n = 2'd3;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{is_write: 1'b1, reg_offset: arg_q[5:0], reg_value: val_q,
                          play_status: status_q, frames_left: skip_q,
                          bad_opcode: bad_q, last: 1'b0};
        end
      end
      ST_DIV: begin
        if (div_done) skip_d = div_quo;
      end
      ST_REPORT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{is_write: 1'b0, reg_offset: 6'd0, reg_value: 8'd0,
                          play_status: status_q, frames_left: skip_q,
                          bad_opcode: bad_q, last: 1'b1};
        end
      end
      default: ;
    endcase

    if (consume_n != 2'd0) begin
      fill_d     = fill_q - CW'(consume_n);
      consumed_d = consumed_q + 32'(consume_n);
    end
  end

  // read point moves on consume and restarts with the ring
  always_comb begin
    rd_ptr_d = ptr_add(rd_ptr_q, consume_n);
    if (state_q == ST_IDLE && in_fire && in_data_i.kind == KIND_RESTART) rd_ptr_d = '0;
  end

  always_comb begin
    case (state_q)
      ST_OP:   raddr = ptr_add(rd_ptr_q, 2'd1);
      ST_ARG1: raddr = ptr_add(rd_ptr_q, 2'd2);
      default: raddr = rd_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire && in_data_i.kind == KIND_PUSH &&
        fill_q < CW'(FIFO_DEPTH)) begin
      ring[wr_ptr_q] <= in_data_i.byte_in;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= ring[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      consumed_q  <= '0;
      len_q       <= '0;
      skip_q      <= '0;
      status_q    <= STAT_PLAYING;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      consumed_q  <= consumed_d;
      skip_q      <= skip_d;
      status_q    <= status_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    arg_q      <= arg_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  scss_frame_div #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({rdata_q, arg_q}),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/scss_checker.sv =====
`default_nettype none

module scss_checker import scss_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire scss_in_t    in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire scss_out_t   out_data_o
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a tick transfer closes the input until its run is reported
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == KIND_TICK |=> !in_ready_o)
    else $error("input taken during a tick");

  // a pending write result means the tick is still running
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input open before final result");

  // writes only come out while playing, never as the final result
  a_write_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_write |->
      !out_data_o.last && out_data_o.play_status == STAT_PLAYING)
    else $error("malformed write result");

endmodule

bind sound_command_stream_sequencer_unit scss_checker u_scss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
